// File: hdl/iplpc_pkg.sv
package iplpc_pkg;

    // item kinds
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // configuration register indexes
    localparam logic CFG_DEFAULT_DISPOSITION = 1'b0;
    localparam logic CFG_DEFAULT_TUNNEL      = 1'b1;

    // disposition codes
    localparam logic [1:0] DISP_TUNNEL = 2'd0;
    localparam logic [1:0] DISP_DIRECT = 2'd1;
    localparam logic [1:0] DISP_BLOCK  = 2'd2;

    localparam logic [5:0] MAX_PREFIX = 6'd32;

    typedef struct packed {
        logic              cmd;
        logic [5:0]        rule_index;
        logic              rule_enabled;
        logic [31:0]       address;
        logic [5:0]        prefix_len;
        logic              port_valid;
        logic [15:0]       port;
        logic              transport_valid;
        logic [1:0]        transport;
        logic signed [15:0] priority_req;
        logic [1:0]        disposition;
        logic [7:0]        tunnel_index;
    } in_item_t;

    typedef struct packed {
        logic       matched;
        logic [5:0] matched_rule;
        logic [1:0] route_disposition;
        logic [7:0] route_tunnel;
    } out_item_t;

    // one table entry: match fields then action fields
    typedef struct packed {
        logic               enabled;
        logic [31:0]        network;
        logic [5:0]         plen;
        logic               port_on;
        logic [15:0]        port;
        logic               tr_on;
        logic [1:0]         tr;
        logic signed [15:0] priority_val;
        logic [1:0]         disp;
        logic [7:0]         tunnel;
    } rule_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic wr_en;
        logic clr_en;
        logic rd_en;
        logic publish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } ctl_stat_t;

    // unused disposition code maps to block
    function automatic logic [1:0] sat_disp(input logic [1:0] d);
        return (d > DISP_BLOCK) ? DISP_BLOCK : d;
    endfunction

    // leading-ones mask for a prefix length of 0 to 32
    function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
        logic [5:0] sh;
        sh = MAX_PREFIX - plen;
        if (plen == 6'd0) begin
            return 32'd0;
        end
        return 32'hFFFF_FFFF << sh[4:0];
    endfunction

endpackage

// File: hdl/iplpc_ctrl.sv
module iplpc_ctrl #(
    parameter int NUM_RULES = 64,
    parameter int AW        = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_cmd,
    output logic                 s_ready,
    input  iplpc_pkg::ctl_stat_t stat,
    output iplpc_pkg::ctl_cmd_t  cmd,
    output logic [AW-1:0]        addr
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_RULES - 1);

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          cnt_last;

    assign cnt_last = (cnt_reg == LAST_ADDR);
    assign addr     = cnt_reg;

    // state and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (cnt_last) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == iplpc_pkg::CMD_WRITE) begin
                        cmd.wr_en = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (cnt_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FLUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/iplpc_dp.sv
module iplpc_dp #(
    parameter int NUM_RULES = 64,
    parameter int AW        = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  iplpc_pkg::in_item_t  s_payload,
    input  iplpc_pkg::ctl_cmd_t  cmd,
    input  logic [AW-1:0]        addr,
    output iplpc_pkg::ctl_stat_t stat,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output iplpc_pkg::out_item_t m_payload
);

    iplpc_pkg::rule_t mem [NUM_RULES];

    iplpc_pkg::rule_t    rd_data_reg;
    logic                rd_valid_reg;
    logic [AW-1:0]       rd_idx_reg;
    iplpc_pkg::in_item_t req_reg;

    logic                best_found_reg;
    logic [AW-1:0]       best_idx_reg;
    logic [5:0]          best_plen_reg;
    logic signed [15:0]  best_prio_reg;
    logic [1:0]          best_disp_reg;
    logic [7:0]          best_tun_reg;

    logic [1:0]          default_disp_reg;
    logic [7:0]          default_tun_reg;

    logic                m_valid_reg;
    iplpc_pkg::out_item_t m_payload_reg;

    iplpc_pkg::rule_t    new_rule;
    iplpc_pkg::rule_t    wr_data;
    logic [AW-1:0]       wr_addr;
    logic                wr_go;
    logic                idx_ok;
    logic [5:0]          plen_sat;
    logic                hit;
    logic                better;

    // rule build from a write transfer
    always_comb begin
        plen_sat = (s_payload.prefix_len > iplpc_pkg::MAX_PREFIX) ?
                   iplpc_pkg::MAX_PREFIX : s_payload.prefix_len;
        new_rule.enabled      = s_payload.rule_enabled;
        new_rule.plen         = plen_sat;
        new_rule.network      = s_payload.address & iplpc_pkg::prefix_mask(plen_sat);
        new_rule.port_on      = s_payload.port_valid;
        new_rule.port         = s_payload.port;
        new_rule.tr_on        = s_payload.transport_valid;
        new_rule.tr           = s_payload.transport;
        new_rule.priority_val = s_payload.priority_req;
        new_rule.disp         = iplpc_pkg::sat_disp(s_payload.disposition);
        new_rule.tunnel       = s_payload.tunnel_index;
    end

    // single write port shared by the clearing sweep and rule writes
    assign idx_ok  = ({26'd0, s_payload.rule_index} < 32'(NUM_RULES));
    assign wr_go   = cmd.clr_en || (cmd.wr_en && idx_ok);
    assign wr_addr = cmd.clr_en ? addr : AW'(s_payload.rule_index);
    assign wr_data = cmd.clr_en ? '0 : new_rule;

    // table memory
    always_ff @(posedge aclk) begin
        if (wr_go) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[addr];
            rd_idx_reg  <= addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_en;
        end
    end

    // lookup request held for the scan
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_reg <= s_payload;
        end
    end

    // candidate test and ranking against the current best
    always_comb begin
        hit = rd_data_reg.enabled &&
              ((req_reg.address & iplpc_pkg::prefix_mask(rd_data_reg.plen))
               == rd_data_reg.network) &&
              (!rd_data_reg.port_on ||
               (req_reg.port_valid && (rd_data_reg.port == req_reg.port))) &&
              (!rd_data_reg.tr_on ||
               (req_reg.transport_valid && (rd_data_reg.tr == req_reg.transport)));
        better = !best_found_reg ||
                 (rd_data_reg.plen > best_plen_reg) ||
                 ((rd_data_reg.plen == best_plen_reg) &&
                  (rd_data_reg.priority_val > best_prio_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
        end else if (cmd.start) begin
            best_found_reg <= 1'b0;
        end else if (rd_valid_reg && hit && better) begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && hit && better) begin
            best_idx_reg  <= rd_idx_reg;
            best_plen_reg <= rd_data_reg.plen;
            best_prio_reg <= rd_data_reg.priority_val;
            best_disp_reg <= rd_data_reg.disp;
            best_tun_reg  <= rd_data_reg.tunnel;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_disp_reg <= iplpc_pkg::DISP_TUNNEL;
            default_tun_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                iplpc_pkg::CFG_DEFAULT_DISPOSITION:
                    default_disp_reg <= iplpc_pkg::sat_disp(cfg_data[1:0]);
                iplpc_pkg::CFG_DEFAULT_TUNNEL:
                    default_tun_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            if (best_found_reg) begin
                m_payload_reg.matched           <= 1'b1;
                m_payload_reg.matched_rule      <= 6'(best_idx_reg);
                m_payload_reg.route_disposition <= best_disp_reg;
                m_payload_reg.route_tunnel      <= best_tun_reg;
            end else begin
                m_payload_reg.matched           <= 1'b0;
                m_payload_reg.matched_rule      <= '0;
                m_payload_reg.route_disposition <= default_disp_reg;
                m_payload_reg.route_tunnel      <= default_tun_reg;
            end
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_payload     = m_payload_reg;

endmodule

// File: hdl/ip_rule_longest_prefix_classifier.sv
// IPv4 longest-prefix rule classifier.
// Input channel s_valid/s_ready/s_payload carries two kinds of transfer: a rule
// write loads one table slot and yields no result; a lookup scans every slot and
// yields one result on m_valid/m_ready/m_payload.
// A lookup reads the table through its single memory read port, one rule per
// cycle, passes a flush state and then waits in a done state until the output
// register is free; no new item is taken until its result is registered.
// Writes to slots at or beyond NUM_RULES are dropped.
// Ranking: longest prefix, then larger signed priority, then lower slot.
// Unmatched lookups return the default disposition and tunnel set through the
// cfg_wr_en/cfg_index/cfg_data port (index 0 disposition, 1 tunnel).
// After reset the block sweeps the table to disabled, one slot a cycle, with
// s_ready low; configuration writes are taken meanwhile.
// The result sits in an output register: while the receiver stalls, a new item
// is still accepted and worked on, and its result waits until the register
// frees up.
module ip_rule_longest_prefix_classifier #(
    parameter int NUM_RULES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  iplpc_pkg::in_item_t  s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output iplpc_pkg::out_item_t m_payload,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int AW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

    iplpc_pkg::ctl_cmd_t  cmd;
    iplpc_pkg::ctl_stat_t stat;
    logic [AW-1:0]        addr;

    // sequencer
    iplpc_ctrl #(
        .NUM_RULES (NUM_RULES),
        .AW        (AW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_payload.cmd),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd),
        .addr    (addr)
    );

    // table, ranking and output register
    iplpc_dp #(
        .NUM_RULES (NUM_RULES),
        .AW        (AW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .addr      (addr),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // table reads never share a cycle with writes
    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && (cmd.wr_en || cmd.clr_en)))
        else $error("table read and write in the same cycle");

    // no read still in flight when a new item can be taken
    a_idle_no_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.rd_en && !u_dp.rd_valid_reg)
        else $error("scan active while input is ready");

    // the clearing sweep holds off input right after reset
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("input ready before the table was cleared");

    // an unmatched result reports slot zero
    a_unmatched_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.matched) |-> (m_payload.matched_rule == 6'd0))
        else $error("unmatched result with nonzero slot");

endmodule

// File: sim/tb_ip_rule_longest_prefix_classifier.sv
module tb_ip_rule_longest_prefix_classifier;

    localparam int NUM_RULES = 64;
    localparam logic [1:0] DISP_UNUSED = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    iplpc_pkg::in_item_t  s_payload;
    logic                 m_valid;
    logic                 m_ready;
    iplpc_pkg::out_item_t m_payload;
    logic                 cfg_wr_en;
    logic                 cfg_index;
    logic [7:0]           cfg_data;

    // one table slot as the checker keeps it
    typedef struct {
        bit        enabled;
        bit [31:0] net;
        bit [31:0] mask;
        bit [5:0]  plen;
        bit        port_on;
        bit [15:0] port;
        bit        tr_on;
        bit [1:0]  tr;
        int        prio;
        bit [1:0]  disp;
        bit [7:0]  tunnel;
    } rule_slot_t;

    // rule table mirror and queue of routes still owed by the block
    class route_checker;
        rule_slot_t           slots[NUM_RULES];
        bit [1:0]             default_disp;
        bit [7:0]             default_tunnel;
        iplpc_pkg::out_item_t pending_routes[$];
        int                   mismatches;

        function bit [1:0] clamp_disp(logic [1:0] d);
            return (d > iplpc_pkg::DISP_BLOCK) ? iplpc_pkg::DISP_BLOCK : d;
        endfunction

        function void take_register(logic idx, logic [7:0] data);
            if (idx == iplpc_pkg::CFG_DEFAULT_DISPOSITION) begin
                default_disp = clamp_disp(data[1:0]);
            end else begin
                default_tunnel = data;
            end
        endfunction

        // apply a rule write, or rank the table for a lookup
        function void take_item(iplpc_pkg::in_item_t it);
            rule_slot_t           s;
            iplpc_pkg::out_item_t r;
            int                   best;
            bit [5:0]             plen;
            if (it.cmd == iplpc_pkg::CMD_WRITE) begin
                if (it.rule_index >= NUM_RULES) begin
                    return;
                end
                plen = (it.prefix_len > iplpc_pkg::MAX_PREFIX) ?
                       iplpc_pkg::MAX_PREFIX : it.prefix_len;
                s.enabled = it.rule_enabled;
                s.plen    = plen;
                s.mask    = ~(32'hFFFF_FFFF >> plen);
                s.net     = it.address & s.mask;
                s.port_on = it.port_valid;
                s.port    = it.port;
                s.tr_on   = it.transport_valid;
                s.tr      = it.transport;
                s.prio    = $signed(it.priority_req);
                s.disp    = clamp_disp(it.disposition);
                s.tunnel  = it.tunnel_index;
                slots[it.rule_index] = s;
                return;
            end
            best = -1;
            for (int i = 0; i < NUM_RULES; i++) begin
                if (!slots[i].enabled || (it.address & slots[i].mask) != slots[i].net) begin
                    continue;
                end
                if (slots[i].port_on && (!it.port_valid || slots[i].port != it.port)) begin
                    continue;
                end
                if (slots[i].tr_on && (!it.transport_valid || slots[i].tr != it.transport)) begin
                    continue;
                end
                // longest prefix, then larger priority, lowest slot on a full tie
                if (best < 0 || slots[i].plen > slots[best].plen ||
                    (slots[i].plen == slots[best].plen && slots[i].prio > slots[best].prio)) begin
                    best = i;
                end
            end
            if (best >= 0) begin
                r.matched           = 1'b1;
                r.matched_rule      = 6'(best);
                r.route_disposition = slots[best].disp;
                r.route_tunnel      = slots[best].tunnel;
            end else begin
                r.matched           = 1'b0;
                r.matched_rule      = 6'd0;
                r.route_disposition = default_disp;
                r.route_tunnel      = default_tunnel;
            end
            pending_routes.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_route(iplpc_pkg::out_item_t got);
            iplpc_pkg::out_item_t want;
            if (pending_routes.size() == 0) begin
                $display("%0t: route with no lookup pending, expected none, actual %0h",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_routes.pop_front();
            compare_field("matched", 32'(want.matched), 32'(got.matched));
            compare_field("matched_rule", 32'(want.matched_rule), 32'(got.matched_rule));
            compare_field("route_disposition", 32'(want.route_disposition),
                          32'(got.route_disposition));
            compare_field("route_tunnel", 32'(want.route_tunnel), 32'(got.route_tunnel));
        endfunction

        function int pending();
            return pending_routes.size();
        endfunction
    endclass

    route_checker sb = new();
    bit sender_quiet;
    bit receiver_quiet;

    ip_rule_longest_prefix_classifier #(
        .NUM_RULES(NUM_RULES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    initial begin
        #(8 * 1_000_000);
        $display("tb: failure");
        $finish;
    end

    // item with every bit random, fields set afterwards as needed
    function automatic iplpc_pkg::in_item_t noise_item();
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        return noise[$bits(iplpc_pkg::in_item_t)-1:0];
    endfunction

    function automatic iplpc_pkg::in_item_t rule_item(
        input logic [5:0] idx, input logic [31:0] addr,
        input logic [5:0] plen, input logic [15:0] prio,
        input logic [1:0] disp, input logic [7:0] tun);
        iplpc_pkg::in_item_t it;
        it = noise_item();
        it.cmd             = iplpc_pkg::CMD_WRITE;
        it.rule_index      = idx;
        it.rule_enabled    = 1'b1;
        it.address         = addr;
        it.prefix_len      = plen;
        it.port_valid      = 1'b0;
        it.transport_valid = 1'b0;
        it.priority_req    = prio;
        it.disposition     = disp;
        it.tunnel_index    = tun;
        return it;
    endfunction

    function automatic iplpc_pkg::in_item_t lookup_item(
        input logic [31:0] addr, input logic pv,
        input logic [15:0] port, input logic tv,
        input logic [1:0] tr);
        iplpc_pkg::in_item_t it;
        it = noise_item();
        it.cmd             = iplpc_pkg::CMD_LOOKUP;
        it.address         = addr;
        it.port_valid      = pv;
        it.port            = port;
        it.transport_valid = tv;
        it.transport       = tr;
        return it;
    endfunction

    // a few shared networks so that prefixes nest and overlap
    function automatic logic [31:0] pick_network();
        logic [31:0] base;
        case ($urandom_range(0, 4))
            0: base = 32'h0A00_0000;
            1: base = 32'hC0A8_0100;
            2: base = 32'hAC10_0000;
            3: base = 32'h0A0A_0000;
            default: base = $urandom;
        endcase
        return base | ($urandom & (32'hFFFF_FFFF >> $urandom_range(8, 32)));
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 6))
            0: return 16'd80;
            1: return 16'd443;
            2: return 16'd53;
            3: return 16'd0;
            4: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic iplpc_pkg::in_item_t random_rule();
        iplpc_pkg::in_item_t it;
        it = noise_item();
        it.cmd             = iplpc_pkg::CMD_WRITE;
        it.rule_enabled    = ($urandom_range(0, 6) != 0);
        it.address         = pick_network();
        it.port_valid      = ($urandom_range(0, 3) == 0);
        it.port            = pick_port();
        it.transport_valid = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0: it.prefix_len = 6'($urandom_range(33, 63));
            1, 2: it.prefix_len = 6'($urandom_range(0, 7));
            default: it.prefix_len = 6'($urandom_range(8, 32));
        endcase
        // half the priorities small, so that equal prefixes tie often
        case ($urandom_range(0, 7))
            0: it.priority_req = 16'sh8000;
            1: it.priority_req = 16'sh7FFF;
            2, 3: it.priority_req = 16'($urandom);
            default: it.priority_req = 16'(int'($urandom_range(0, 4)) - 2);
        endcase
        return it;
    endfunction

    function automatic iplpc_pkg::in_item_t random_lookup();
        iplpc_pkg::in_item_t it;
        rule_slot_t          s;
        it = noise_item();
        it.cmd             = iplpc_pkg::CMD_LOOKUP;
        it.address         = pick_network();
        it.port_valid      = ($urandom_range(0, 1) == 1);
        it.port            = pick_port();
        it.transport_valid = ($urandom_range(0, 1) == 1);
        // most lookups land inside some slot's network, filters mostly agreeing
        if ($urandom_range(0, 9) < 6) begin
            s = sb.slots[$urandom_range(0, NUM_RULES - 1)];
            it.address = s.net | ($urandom & ~s.mask);
            if (s.port_on && $urandom_range(0, 4) != 0) begin
                it.port_valid = 1'b1;
                it.port       = s.port;
            end
            if (s.tr_on && $urandom_range(0, 4) != 0) begin
                it.transport_valid = 1'b1;
                it.transport       = s.tr;
            end
        end
        return it;
    endfunction

    // offer one item and hold it until the transfer
    task automatic send_item(input iplpc_pkg::in_item_t it);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        sb.take_item(it);
    endtask

    // stop offering until every owed route has come back
    task automatic drain_routes();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_defaults(input logic [7:0] disp_data, input logic [7:0] tunnel_data);
        cfg_wr_en <= 1'b1;
        cfg_index <= iplpc_pkg::CFG_DEFAULT_DISPOSITION;
        cfg_data  <= disp_data;
        @(posedge aclk);
        sb.take_register(iplpc_pkg::CFG_DEFAULT_DISPOSITION, disp_data);
        cfg_index <= iplpc_pkg::CFG_DEFAULT_TUNNEL;
        cfg_data  <= tunnel_data;
        @(posedge aclk);
        sb.take_register(iplpc_pkg::CFG_DEFAULT_TUNNEL, tunnel_data);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off to back up the input
    initial begin : route_sink
        int results;
        int stall;
        results = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results % 16 == 0) begin
                receiver_quiet = ($urandom_range(0, 3) == 0);
            end
            stall = receiver_quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                if ($urandom_range(0, 1) == 1) begin
                    while (!m_valid) @(posedge aclk);
                end
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_route(m_payload);
            results++;
            if (results == 30) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
            end
        end
    end

    // stimulus
    initial begin : item_source
        iplpc_pkg::in_item_t it;
        int                  write_pct;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= iplpc_pkg::CFG_DEFAULT_DISPOSITION;
        cfg_data  <= 8'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // unused disposition code on the default saturates to block
        write_defaults({6'd0, DISP_UNUSED}, 8'hFF);

        // empty table gives the default
        send_item(lookup_item(32'h0000_0000, 1'b0, 16'd0, 1'b0, 2'd0));
        send_item(lookup_item(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 2'd3));
        // default route, then three /8 rules with priority and index ties
        send_item(rule_item(6'd0, 32'h0000_0000, 6'd0, 16'sd0,
                            iplpc_pkg::DISP_TUNNEL, 8'd1));
        send_item(rule_item(6'd63, 32'h0A01_0203, 6'd8, 16'sh8000,
                            iplpc_pkg::DISP_DIRECT, 8'd2));
        send_item(rule_item(6'd5, 32'h0A00_0000, 6'd8, 16'sh7FFF,
                            iplpc_pkg::DISP_BLOCK, 8'd3));
        send_item(rule_item(6'd7, 32'h0AFF_0000, 6'd8, 16'sh7FFF, DISP_UNUSED, 8'd4));
        // prefix above 32 saturates
        send_item(rule_item(6'd9, 32'hC0A8_0101, 6'd40, 16'sd0,
                            iplpc_pkg::DISP_DIRECT, 8'd5));
        it = rule_item(6'd10, 32'hC0A8_0100, 6'd24, 16'sd0, iplpc_pkg::DISP_TUNNEL, 8'd6);
        it.port_valid = 1'b1;
        it.port       = 16'd443;
        send_item(it);
        it = rule_item(6'd11, 32'hC0A8_0100, 6'd24, 16'sd1, iplpc_pkg::DISP_BLOCK, 8'd7);
        it.transport_valid = 1'b1;
        it.transport       = 2'd1;
        send_item(it);
        it = rule_item(6'd12, 32'hFFFF_FFFF, 6'd32, 16'sd0, iplpc_pkg::DISP_DIRECT, 8'd8);
        it.rule_enabled = 1'b0;
        send_item(it);
        it = rule_item(6'd13, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, iplpc_pkg::DISP_DIRECT, 8'hFF);
        it.port_valid      = 1'b1;
        it.port            = 16'hFFFF;
        it.transport_valid = 1'b1;
        it.transport       = 2'd3;
        send_item(it);
        send_item(lookup_item(32'h0A09_0909, 1'b0, 16'd0, 1'b0, 2'd0));
        send_item(lookup_item(32'hC0A8_0101, 1'b0, 16'd0, 1'b0, 2'd0));
        send_item(lookup_item(32'hC0A8_0102, 1'b1, 16'd443, 1'b0, 2'd1));
        send_item(lookup_item(32'hC0A8_0102, 1'b1, 16'd443, 1'b1, 2'd1));
        // port present but not flagged valid must not satisfy a port filter
        send_item(lookup_item(32'hC0A8_0102, 1'b0, 16'd443, 1'b0, 2'd1));
        send_item(lookup_item(32'hC0A8_0102, 1'b1, 16'd80, 1'b1, 2'd1));
        send_item(lookup_item(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 2'd3));
        send_item(lookup_item(32'hFFFF_FFFF, 1'b1, 16'hFFFE, 1'b1, 2'd3));
        it = rule_item(6'd0, 32'h0000_0000, 6'd0, 16'sd0, iplpc_pkg::DISP_TUNNEL, 8'd1);
        it.rule_enabled = 1'b0;
        send_item(it);
        send_item(lookup_item(32'h0808_0808, 1'b0, 16'd0, 1'b0, 2'd0));
        send_item(lookup_item(32'h0000_0000, 1'b1, 16'd0, 1'b1, 2'd0));

        // random phases, defaults rewritten between them while idle
        for (int phase = 0; phase < 6; phase++) begin
            drain_routes();
            repeat (NUM_RULES + 8) @(posedge aclk);
            case (phase)
                0: write_defaults({6'd0, iplpc_pkg::DISP_TUNNEL}, 8'd0);
                1: write_defaults(8'hFF, 8'hFF);
                2: write_defaults({6'd0, iplpc_pkg::DISP_DIRECT}, 8'h80);
                default: write_defaults(8'($urandom), 8'($urandom));
            endcase
            write_pct = (phase == 0) ? 50 : (phase == 5) ? 10 : 30;
            for (int i = 0; i < 300; i++) begin
                if (i % 40 == 0) begin
                    sender_quiet = ($urandom_range(0, 3) == 0);
                end
                if (phase == 3 && i == 150) begin
                    drain_routes();
                end
                if ($urandom_range(0, 99) < write_pct) begin
                    send_item(random_rule());
                end else begin
                    send_item(random_lookup());
                end
            end
        end

        drain_routes();
        repeat (NUM_RULES + 8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
